### rtl/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg
// Shared widths, queue entry type and cell-row control for the Huffman
// tree builder.
// ----------------------------------------------------------------------------
package htb_pkg;

    localparam int SYM_W          = 8;
    localparam int LEAF_FREQ_W    = 24;
    localparam int FREQ_W         = 30;
    localparam int ID_W           = 7;
    localparam int MAX_LEAVES_DEF = 64;

    // one queue entry as held by a cell
    typedef struct packed {
        logic              valid;
        logic [FREQ_W-1:0] freq;
        logic [ID_W-1:0]   node;
        logic [SYM_W-1:0]  sym;
    } t_entry;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_INSERT,
        ROW_POP2,
        ROW_CLEAR
    } t_row_op;

    // broadcast to every cell of the row
    typedef struct packed {
        t_row_op op;
        t_entry  new_entry;
    } t_row_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_INS
    } t_state;

endpackage

### rtl/htb_cell.sv
// ----------------------------------------------------------------------------
// htb_cell
// One slot of the sorted queue. Keeps its entry, takes the broadcast entry,
// takes its lower neighbor's entry on insert, or the entry two slots up on
// a double pop, and clears its valid bit on clear.
// ----------------------------------------------------------------------------
module htb_cell
    import htb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_row_ctl i_ctl,
    input  t_entry   i_prev,
    input  logic     i_prev_lt,
    input  t_entry   i_next2,
    output t_entry   o_entry,
    output logic     o_lt
);

    logic              r_valid;
    logic [FREQ_W-1:0] r_freq;
    logic [ID_W-1:0]   r_node;
    logic [SYM_W-1:0]  r_sym;
    t_entry            w_cur;
    t_entry            n_entry;

    assign w_cur   = '{valid: r_valid, freq: r_freq, node: r_node, sym: r_sym};
    assign o_entry = w_cur;
    // entries strictly smaller than the new one stay below it
    assign o_lt    = r_valid && (r_freq < i_ctl.new_entry.freq);

    always_comb begin
        n_entry = w_cur;
        case (i_ctl.op)
            ROW_HOLD: begin
                n_entry = w_cur;
            end
            ROW_INSERT: begin
                if (o_lt) begin
                    n_entry = w_cur;
                end else if (i_prev_lt) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_prev;
                end
            end
            ROW_POP2: begin
                n_entry = i_next2;
            end
            ROW_CLEAR: begin
                n_entry       = w_cur;
                n_entry.valid = 1'b0;
            end
            default: begin
                n_entry = w_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_freq <= n_entry.freq;
        r_node <= n_entry.node;
        r_sym  <= n_entry.sym;
    end

endmodule

### rtl/htb_queue.sv
// ----------------------------------------------------------------------------
// htb_queue
// Row of cells kept sorted by ascending frequency from slot 0. Ties place
// a newer entry nearer slot 0, so the two smallest always sit in slots 0, 1.
// ----------------------------------------------------------------------------
module htb_queue
    import htb_pkg::*;
#(
    parameter int DEPTH = MAX_LEAVES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_row_ctl i_ctl,
    output t_entry   o_head0,
    output t_entry   o_head1,
    output t_entry   o_head2
);

    t_entry w_entry [DEPTH];
    logic   w_lt    [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_entry w_prev;
        logic   w_prev_lt;
        t_entry w_next2;

        if (k == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_lt = 1'b1;
        end else begin : g_mid
            assign w_prev    = w_entry[k-1];
            assign w_prev_lt = w_lt[k-1];
        end

        if (k + 2 < DEPTH) begin : g_up
            assign w_next2 = w_entry[k+2];
        end else begin : g_top
            assign w_next2 = '0;
        end

        htb_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (i_ctl),
            .i_prev    (w_prev),
            .i_prev_lt (w_prev_lt),
            .i_next2   (w_next2),
            .o_entry   (w_entry[k]),
            .o_lt      (w_lt[k])
        );
    end

    assign o_head0 = w_entry[0];
    assign o_head1 = w_entry[1];

    if (DEPTH > 2) begin : g_head2
        assign o_head2 = w_entry[2];
    end else begin : g_no_head2
        assign o_head2 = '0;
    end

endmodule

### rtl/huffman_tree_builder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_builder_top
// Loads leaves into a sorted cell row and emits one merge per internal node.
// ----------------------------------------------------------------------------
// Each accepted leaf is placed in sorted position by the cell row as it is
// taken, and the input stays ready for the next leaf. After the leaf marked
// final, the input side stays not ready while the tree is built; each merge
// but the last pops the two smallest slots and registers the result (ST_POP),
// then reinserts the merged node through the row (ST_INS), and the root merge
// registers its result and clears the row. A stalled result holds the merge
// loop. Leaves past MAX_LEAVES are dropped; a set of one leaf emits nothing.
// The root result may still wait in the output register while leaves of the
// next set are loaded.
// ----------------------------------------------------------------------------
module huffman_tree_builder_top
    import htb_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SYM_W-1:0]       i_leaf_symbol,
    input  logic [LEAF_FREQ_W-1:0] i_leaf_frequency,
    input  logic                   i_final_leaf,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [ID_W-1:0]        o_node_id,
    output logic [ID_W-1:0]        o_left_id,
    output logic [ID_W-1:0]        o_right_id,
    output logic [SYM_W-1:0]       o_left_symbol,
    output logic [SYM_W-1:0]       o_right_symbol,
    output logic [FREQ_W-1:0]      o_node_frequency,
    output logic                   o_root_done
);

    localparam int LCNT_W = $clog2(MAX_LEAVES + 1);

    t_state            r_state, n_state;
    logic [LCNT_W-1:0] r_leaves;
    logic [ID_W-1:0]   r_next_id;
    t_entry            r_pend;
    logic              r_out_valid;

    t_row_ctl          w_ctl;
    t_entry            w_head0, w_head1, w_head2;
    logic [FREQ_W-1:0] w_sum;
    logic              w_in_acc, w_room, w_out_free, w_fire, w_done;

    htb_queue #(
        .DEPTH (MAX_LEAVES)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head0 (w_head0),
        .o_head1 (w_head1),
        .o_head2 (w_head2)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_room     = (r_leaves != LCNT_W'(MAX_LEAVES));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_sum      = w_head0.freq + w_head1.freq;
    assign w_fire     = (r_state == ST_POP) && w_head1.valid && w_out_free;
    // end of the set: nothing to merge, or the root just went out
    assign w_done     = (r_state == ST_POP) &&
                        (!w_head1.valid || (w_fire && !w_head2.valid));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_final_leaf) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end else if (w_fire) begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                n_state = ST_POP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl.op        = ROW_HOLD;
        w_ctl.new_entry = r_pend;
        case (r_state)
            ST_IDLE: begin
                w_ctl.new_entry = '{valid: 1'b1,
                                    freq:  FREQ_W'(i_leaf_frequency),
                                    node:  ID_W'(r_leaves),
                                    sym:   i_leaf_symbol};
                if (w_in_acc && w_room) begin
                    w_ctl.op = ROW_INSERT;
                end
            end
            ST_POP: begin
                if (w_done) begin
                    w_ctl.op = ROW_CLEAR;
                end else if (w_fire) begin
                    w_ctl.op = ROW_POP2;
                end
            end
            ST_INS: begin
                w_ctl.op = ROW_INSERT;
            end
            default: begin
                w_ctl.op = ROW_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_leaves    <= '0;
            r_next_id   <= ID_W'(MAX_LEAVES);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_leaves  <= '0;
                r_next_id <= ID_W'(MAX_LEAVES);
            end else begin
                if (w_in_acc && w_room) begin
                    r_leaves <= r_leaves + LCNT_W'(1);
                end
                if (r_state == ST_INS) begin
                    r_next_id <= r_next_id + ID_W'(1);
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result and pending merged node; internal nodes carry symbol zero
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pend           <= '{valid: 1'b1, freq: w_sum, node: r_next_id, sym: '0};
            o_node_id        <= r_next_id;
            o_left_id        <= w_head1.node;
            o_right_id       <= w_head0.node;
            o_left_symbol    <= w_head1.sym;
            o_right_symbol   <= w_head0.sym;
            o_node_frequency <= w_sum;
            o_root_done      <= !w_head2.valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/htb_checker.sv
// ----------------------------------------------------------------------------
// htb_checker
// Port-level checks on the Huffman tree builder, bound to the top level.
// ----------------------------------------------------------------------------
module htb_checker
    import htb_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   i_final_leaf,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [ID_W-1:0]        o_node_id,
    input logic [ID_W-1:0]        o_left_id,
    input logic [ID_W-1:0]        o_right_id,
    input logic [FREQ_W-1:0]      o_node_frequency,
    input logic                   o_root_done
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_node_id)
            && $stable(o_node_frequency) && $stable(o_root_done))
        else $error("result dropped or changed while stalled");

    // building starts right after the final leaf
    a_build_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_final_leaf |=> !o_in_ready)
        else $error("input still ready after final leaf");

    // loading continues after an ordinary leaf
    a_load_go_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_final_leaf |=> o_in_ready)
        else $error("input stalled after ordinary leaf");

    // merged ids are internal and children differ
    a_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_node_id >= ID_W'(MAX_LEAVES)) && (o_left_id != o_right_id)
            && (o_left_id != o_node_id) && (o_right_id != o_node_id))
        else $error("bad node or child id");

endmodule

bind huffman_tree_builder_top htb_checker #(.MAX_LEAVES(MAX_LEAVES)) u_htb_checker (.*);
